### hw/rtl/rat_pkg.sv
// Shared types, constants and helpers of the resource allocation table.
// No dependencies; every other file of the block but rat_ram uses it.
`default_nettype none

package rat_pkg;

  localparam int NUM_PROCS = 32;
  localparam int NUM_RES   = 32;
  localparam int DEPTH     = NUM_PROCS * NUM_RES;
  localparam int ADDR_W    = $clog2(DEPTH);
  localparam int RIDX_W    = (NUM_RES > 1) ? $clog2(NUM_RES) : 1;
  localparam int CNT_W     = $clog2(NUM_RES + 1);

  localparam int FUNC_W   = 3;
  localparam int PROC_W   = 5;
  localparam int RES_W    = 5;
  localparam int COUNT_W  = 4;
  localparam int STATUS_W = 2;
  localparam int COUNT_MAX = 15;

  typedef logic [COUNT_W-1:0] count_t;
  typedef logic [ADDR_W-1:0]  addr_t;

  typedef enum logic [FUNC_W-1:0] {
    FN_LOAD  = 3'd0,
    FN_CLAIM = 3'd1,
    FN_ACQ   = 3'd2,
    FN_REL   = 3'd3,
    FN_TERM  = 3'd4,
    FN_CHECK = 3'd5
  } func_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK     = 2'd0,
    ST_UNSAFE = 2'd1,
    ST_NOHELD = 2'd2,
    ST_NOFREE = 2'd3
  } status_e;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_RD,
    S_EXEC,
    S_WALK,
    S_DONE
  } state_e;

  typedef struct packed {
    logic   held_we;
    logic   claim_we;
    addr_t  waddr;
    count_t held_wdata;
    count_t claim_wdata;
    addr_t  raddr;
  } mem_req_t;

  function automatic count_t sat_add(count_t a, count_t b);
    logic [COUNT_W:0] s;
    s = {1'b0, a} + {1'b0, b};
    if (s > (COUNT_W + 1)'(COUNT_MAX)) begin
      return count_t'(COUNT_MAX);
    end
    return s[COUNT_W-1:0];
  endfunction

endpackage

`default_nettype wire

### hw/rtl/rat_if.sv
// Valid/ready channels of the resource allocation table: request and response.
// Depends on rat_pkg for field widths.
`default_nettype none

interface rat_req_if;
  logic                          valid;
  logic                          ready;
  logic [rat_pkg::FUNC_W-1:0]    func;
  logic [rat_pkg::PROC_W-1:0]    proc;
  logic [rat_pkg::RES_W-1:0]     resource;
  logic [rat_pkg::COUNT_W-1:0]   amount;

  modport source (output valid, func, proc, resource, amount, input ready);
  modport sink   (input valid, func, proc, resource, amount, output ready);
endinterface

interface rat_rsp_if;
  logic                          valid;
  logic                          ready;
  logic                          ok;
  logic [rat_pkg::STATUS_W-1:0]  status;
  logic [rat_pkg::COUNT_W-1:0]   free_now;
  logic [rat_pkg::COUNT_W-1:0]   held_now;

  modport source (output valid, ok, status, free_now, held_now, input ready);
  modport sink   (input valid, ok, status, free_now, held_now, output ready);
endinterface

`default_nettype wire

### hw/rtl/resource_allocation_table.sv
// Top level of the resource allocation table: sequencer plus held and claim RAMs.
// Depends on rat_pkg, rat_if, rat_ram and rat_ctrl.
`default_nettype none

// Each request word loads a free count, sets a claim, acquires or releases one
// unit, terminates a process or runs a one-process safety check, and yields one
// response word. Held units and claims live in two RAMs of NUM_PROCS*NUM_RES
// entries with one registered read port each; free counts sit in flip-flops.
// After reset the block sweeps both RAMs to zero, one entry per cycle, with
// in_i.ready low. Load, claim, acquire, release and unused codes pass through a
// read state, which issues the registered RAM read, an execute state and a done
// state that loads the response register. Terminate and check with a valid
// process walk its row one resource per cycle through the shared count unit
// and then load the response register from the done state; an invalid process
// goes straight to the done state. A stalled response register holds the
// sequencer in the done state. A new request is taken only when the previous
// one has reached the response register.

module resource_allocation_table (
  input wire logic  clk_i,
  input wire logic  rst_ni,
  rat_req_if.sink   in_i,
  rat_rsp_if.source out_o
);

  rat_pkg::mem_req_t mem_req;
  rat_pkg::count_t   held_rdata;
  rat_pkg::count_t   claim_rdata;

  rat_ctrl u_ctrl (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_i          (in_i),
    .out_o         (out_o),
    .mem_req_o     (mem_req),
    .held_rdata_i  (held_rdata),
    .claim_rdata_i (claim_rdata)
  );

  rat_ram #(
    .W     (rat_pkg::COUNT_W),
    .DEPTH (rat_pkg::DEPTH)
  ) u_held_ram (
    .clk_i   (clk_i),
    .we_i    (mem_req.held_we),
    .waddr_i (mem_req.waddr),
    .wdata_i (mem_req.held_wdata),
    .raddr_i (mem_req.raddr),
    .rdata_o (held_rdata)
  );

  rat_ram #(
    .W     (rat_pkg::COUNT_W),
    .DEPTH (rat_pkg::DEPTH)
  ) u_claim_ram (
    .clk_i   (clk_i),
    .we_i    (mem_req.claim_we),
    .waddr_i (mem_req.waddr),
    .wdata_i (mem_req.claim_wdata),
    .raddr_i (mem_req.raddr),
    .rdata_o (claim_rdata)
  );

endmodule

`default_nettype wire

### hw/rtl/rat_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none

module rat_ram #(
  parameter int W     = 4,
  parameter int DEPTH = 1024
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [W-1:0]             wdata_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output      logic [W-1:0]             rdata_o
);

  logic [W-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rdata_o <= mem[raddr_i];
  end

endmodule

`default_nettype wire

### hw/rtl/rat_ctrl.sv
// Sequencer and shared count unit of the resource allocation table; holds the
// free counts and the response register. Depends on rat_pkg and rat_if.
`default_nettype none

module rat_ctrl (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  rat_req_if.sink                   in_i,
  rat_rsp_if.source                 out_o,
  output      rat_pkg::mem_req_t    mem_req_o,
  input  wire rat_pkg::count_t      held_rdata_i,
  input  wire rat_pkg::count_t      claim_rdata_i
);

  localparam int ADDR_W = rat_pkg::ADDR_W;
  localparam int RIDX_W = rat_pkg::RIDX_W;
  localparam int CNT_W  = rat_pkg::CNT_W;

  rat_pkg::state_e state_q, state_d;

  logic [rat_pkg::FUNC_W-1:0]  func_q, func_d;
  logic [rat_pkg::RES_W-1:0]   res_q, res_d;
  rat_pkg::count_t             amount_q, amount_d;
  logic                        p_ok_q, p_ok_d;
  logic                        r_ok_q, r_ok_d;
  rat_pkg::addr_t              base_q, base_d;
  rat_pkg::addr_t              addr_q, addr_d;
  rat_pkg::addr_t              clr_q, clr_d;
  logic [CNT_W-1:0]            rd_cnt_q, rd_cnt_d;
  logic                        exe_vld_q, exe_vld_d;
  logic [RIDX_W-1:0]           exe_idx_q, exe_idx_d;
  logic                        safe_q, safe_d;
  logic                        ok_q, ok_d;
  rat_pkg::status_e            status_q, status_d;
  rat_pkg::count_t             held_now_q, held_now_d;
  rat_pkg::count_t             free_q [rat_pkg::NUM_RES];
  rat_pkg::count_t             free_d [rat_pkg::NUM_RES];

  logic                        out_valid_q, out_valid_d;
  logic                        out_ok_q, out_ok_d;
  rat_pkg::status_e            out_status_q, out_status_d;
  rat_pkg::count_t             out_free_q, out_free_d;
  rat_pkg::count_t             out_held_q, out_held_d;

  logic              accept;
  logic              walk_func;
  logic              in_p_ok;
  logic              in_r_ok;
  logic [RIDX_W-1:0] r_idx;
  logic              walk_last;
  logic              out_free;
  logic              unsafe_now;

  assign accept    = in_i.valid && in_i.ready;
  assign in_p_ok   = 32'(in_i.proc) < rat_pkg::NUM_PROCS;
  assign in_r_ok   = 32'(in_i.resource) < rat_pkg::NUM_RES;
  assign walk_func = (in_i.func == rat_pkg::FN_TERM) || (in_i.func == rat_pkg::FN_CHECK);
  assign r_idx     = RIDX_W'(res_q);
  assign walk_last = exe_vld_q && (exe_idx_q == RIDX_W'(rat_pkg::NUM_RES - 1));
  assign out_free  = !out_valid_q || out_o.ready;
  assign unsafe_now = ({1'b0, claim_rdata_i} >
                       ({1'b0, held_rdata_i} + {1'b0, free_q[exe_idx_q]}));

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      rat_pkg::S_CLEAR: begin
        if (clr_q == ADDR_W'(rat_pkg::DEPTH - 1)) begin
          state_d = rat_pkg::S_IDLE;
        end
      end
      rat_pkg::S_IDLE: begin
        if (accept) begin
          if (!walk_func) begin
            state_d = rat_pkg::S_RD;
          end else if (in_p_ok) begin
            state_d = rat_pkg::S_WALK;
          end else begin
            state_d = rat_pkg::S_DONE;
          end
        end
      end
      rat_pkg::S_RD:   state_d = rat_pkg::S_EXEC;
      rat_pkg::S_EXEC: state_d = rat_pkg::S_DONE;
      rat_pkg::S_WALK: begin
        if (walk_last) begin
          state_d = rat_pkg::S_DONE;
        end
      end
      rat_pkg::S_DONE: begin
        if (out_free) begin
          state_d = rat_pkg::S_IDLE;
        end
      end
      default: state_d = rat_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    rat_pkg::count_t h;
    rat_pkg::count_t f;
    rat_pkg::count_t held_new;
    h        = held_rdata_i;
    f        = free_q[r_idx];
    held_new = h;

    func_d     = func_q;
    res_d      = res_q;
    amount_d   = amount_q;
    p_ok_d     = p_ok_q;
    r_ok_d     = r_ok_q;
    base_d     = base_q;
    addr_d     = addr_q;
    clr_d      = clr_q;
    rd_cnt_d   = rd_cnt_q;
    exe_vld_d  = 1'b0;
    exe_idx_d  = exe_idx_q;
    safe_d     = safe_q;
    ok_d       = ok_q;
    status_d   = status_q;
    held_now_d = held_now_q;
    free_d     = free_q;

    out_valid_d  = out_valid_q && !out_o.ready;
    out_ok_d     = out_ok_q;
    out_status_d = out_status_q;
    out_free_d   = out_free_q;
    out_held_d   = out_held_q;

    in_i.ready = 1'b0;

    mem_req_o.held_we     = 1'b0;
    mem_req_o.claim_we    = 1'b0;
    mem_req_o.waddr       = addr_q;
    mem_req_o.held_wdata  = '0;
    mem_req_o.claim_wdata = '0;
    mem_req_o.raddr       = addr_q;

    unique case (state_q)
      rat_pkg::S_CLEAR: begin
        mem_req_o.held_we  = 1'b1;
        mem_req_o.claim_we = 1'b1;
        mem_req_o.waddr    = clr_q;
        clr_d              = clr_q + ADDR_W'(1);
      end
      rat_pkg::S_IDLE: begin
        in_i.ready = 1'b1;
        if (accept) begin
          func_d     = in_i.func;
          res_d      = in_i.resource;
          amount_d   = in_i.amount;
          p_ok_d     = in_p_ok;
          r_ok_d     = in_r_ok;
          base_d     = ADDR_W'(32'(in_i.proc) * rat_pkg::NUM_RES);
          addr_d     = ADDR_W'(32'(in_i.proc) * rat_pkg::NUM_RES + 32'(in_i.resource));
          rd_cnt_d   = '0;
          safe_d     = 1'b1;
          ok_d       = 1'b0;
          status_d   = rat_pkg::ST_OK;
          held_now_d = '0;
        end
      end
      rat_pkg::S_RD: begin
        mem_req_o.raddr = addr_q;
      end
      rat_pkg::S_EXEC: begin
        ok_d     = 1'b0;
        status_d = rat_pkg::ST_OK;
        unique case (func_q)
          rat_pkg::FN_LOAD: begin
            if (r_ok_q) begin
              free_d[r_idx] = amount_q;
              ok_d          = 1'b1;
            end
          end
          rat_pkg::FN_CLAIM: begin
            if (p_ok_q && r_ok_q) begin
              mem_req_o.claim_we    = 1'b1;
              mem_req_o.claim_wdata = amount_q;
              ok_d                  = 1'b1;
            end
          end
          rat_pkg::FN_ACQ: begin
            if (p_ok_q && r_ok_q) begin
              if (f == '0) begin
                status_d = rat_pkg::ST_NOFREE;
              end else begin
                free_d[r_idx]        = f - rat_pkg::count_t'(1);
                held_new             = rat_pkg::sat_add(h, rat_pkg::count_t'(1));
                mem_req_o.held_we    = 1'b1;
                mem_req_o.held_wdata = held_new;
                ok_d                 = 1'b1;
              end
            end
          end
          rat_pkg::FN_REL: begin
            if (p_ok_q && r_ok_q) begin
              if (h == '0) begin
                status_d = rat_pkg::ST_NOHELD;
              end else begin
                held_new             = h - rat_pkg::count_t'(1);
                free_d[r_idx]        = rat_pkg::sat_add(f, rat_pkg::count_t'(1));
                mem_req_o.held_we    = 1'b1;
                mem_req_o.held_wdata = held_new;
                ok_d                 = 1'b1;
              end
            end
          end
          default: ;
        endcase
        held_now_d = (p_ok_q && r_ok_q) ? held_new : '0;
      end
      rat_pkg::S_WALK: begin
        mem_req_o.raddr = base_q + ADDR_W'(rd_cnt_q);
        mem_req_o.waddr = base_q + ADDR_W'(exe_idx_q);
        if (rd_cnt_q < CNT_W'(rat_pkg::NUM_RES)) begin
          exe_vld_d = 1'b1;
          exe_idx_d = RIDX_W'(rd_cnt_q);
          rd_cnt_d  = rd_cnt_q + CNT_W'(1);
        end
        if (exe_vld_q) begin
          if (func_q == rat_pkg::FN_TERM) begin
            free_d[exe_idx_q]  = rat_pkg::sat_add(free_q[exe_idx_q], h);
            mem_req_o.held_we  = 1'b1;
            mem_req_o.claim_we = 1'b1;
            if (walk_last) begin
              ok_d = 1'b1;
            end
          end else begin
            if (unsafe_now) begin
              safe_d = 1'b0;
            end
            if (r_ok_q && (exe_idx_q == r_idx)) begin
              held_now_d = h;
            end
            if (walk_last) begin
              ok_d     = safe_q && !unsafe_now;
              status_d = (safe_q && !unsafe_now) ? rat_pkg::ST_OK : rat_pkg::ST_UNSAFE;
            end
          end
        end
      end
      rat_pkg::S_DONE: begin
        if (out_free) begin
          out_valid_d  = 1'b1;
          out_ok_d     = ok_q;
          out_status_d = status_q;
          out_free_d   = r_ok_q ? f : '0;
          out_held_d   = held_now_q;
        end
      end
      default: ;
    endcase
  end

  assign out_o.valid    = out_valid_q;
  assign out_o.ok       = out_ok_q;
  assign out_o.status   = out_status_q;
  assign out_o.free_now = out_free_q;
  assign out_o.held_now = out_held_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= rat_pkg::S_CLEAR;
      clr_q       <= '0;
      rd_cnt_q    <= '0;
      exe_vld_q   <= 1'b0;
      out_valid_q <= 1'b0;
      for (int i = 0; i < rat_pkg::NUM_RES; i++) begin
        free_q[i] <= '0;
      end
    end else begin
      state_q     <= state_d;
      clr_q       <= clr_d;
      rd_cnt_q    <= rd_cnt_d;
      exe_vld_q   <= exe_vld_d;
      out_valid_q <= out_valid_d;
      free_q      <= free_d;
    end
  end

  always_ff @(posedge clk_i) begin
    func_q       <= func_d;
    res_q        <= res_d;
    amount_q     <= amount_d;
    p_ok_q       <= p_ok_d;
    r_ok_q       <= r_ok_d;
    base_q       <= base_d;
    addr_q       <= addr_d;
    exe_idx_q    <= exe_idx_d;
    safe_q       <= safe_d;
    ok_q         <= ok_d;
    status_q     <= status_d;
    held_now_q   <= held_now_d;
    out_ok_q     <= out_ok_d;
    out_status_q <= out_status_d;
    out_free_q   <= out_free_d;
    out_held_q   <= out_held_d;
  end

endmodule

`default_nettype wire

### hw/rtl/rat_chk.sv
// Port-level checks of the resource allocation table, bound to the top level.
// Depends on rat_pkg and resource_allocation_table.
`default_nettype none

module rat_chk (
  input wire logic                         clk_i,
  input wire logic                         rst_ni,
  input wire logic                         in_valid_i,
  input wire logic                         in_ready_i,
  input wire logic                         out_valid_i,
  input wire logic                         out_ready_i,
  input wire logic                         ok_i,
  input wire logic [rat_pkg::STATUS_W-1:0] status_i,
  input wire logic [rat_pkg::COUNT_W-1:0]  free_now_i,
  input wire logic [rat_pkg::COUNT_W-1:0]  held_now_i
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i)
    else $error("response word dropped while stalled");

  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_i |=> !in_ready_i ##1 !in_ready_i)
    else $error("request taken while previous word still in progress");

  a_ok_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && ok_i |-> status_i == rat_pkg::ST_OK)
    else $error("ok set with an error status");

  a_nofree: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && status_i == rat_pkg::ST_NOFREE |-> free_now_i == '0)
    else $error("acquire refused although units are free");

  a_noheld: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && status_i == rat_pkg::ST_NOHELD |-> held_now_i == '0)
    else $error("release refused although units are held");

endmodule

bind resource_allocation_table rat_chk u_rat_chk (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_i.valid),
  .in_ready_i  (in_i.ready),
  .out_valid_i (out_o.valid),
  .out_ready_i (out_o.ready),
  .ok_i        (out_o.ok),
  .status_i    (out_o.status),
  .free_now_i  (out_o.free_now),
  .held_now_i  (out_o.held_now)
);

`default_nettype wire
